>>> rtl/core/display_refresh_sequencer_defines.svh
// Assertion macros shared by the display refresh sequencer RTL.
`ifndef DISPLAY_REFRESH_SEQUENCER_DEFINES_SVH
`define DISPLAY_REFRESH_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/drs_pkg.sv
// Package: constants and types for the display refresh sequencer.
`default_nettype none

package drs_pkg;

   // Default geometry of the frame buffer and of one bus chunk.
   localparam int BUFFER_BYTES_DEF = 512;
   localparam int CHUNK_BYTES_DEF  = 16;

   // Result field widths (fixed by the interface).
   localparam int OFFSET_W = 9;
   localparam int LENGTH_W = 5;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_DATA_W-1:0] REFRESH_IVL_RESET  = 32'd100000;
   localparam logic [CSR_DATA_W-1:0] RECOVERY_IVL_RESET = 32'd1000000;

   // Register indexes (paddr[2]).
   localparam logic REG_REFRESH_IVL  = 1'b0;
   localparam logic REG_RECOVERY_IVL = 1'b1;

   // One result beat.
   typedef struct packed {
      logic                sent_init;
      logic                new_frame;
      logic                chunk_valid;
      logic [OFFSET_W-1:0] chunk_offset;
      logic [LENGTH_W-1:0] chunk_length;
      logic                error_flag;
      logic                frame_done;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/display_refresh_sequencer.sv
// Display refresh sequencer: paces frame refresh and error recovery per service call.
//
// Usage
//   req channel: one beat per service call, carrying the microsecond time and
//     the outcomes of init, window set and chunk write for that call.
//   rsp channel: exactly one beat per req beat, in order, telling which bus
//     steps were tried, the chunk offset/length, error flag and frame end.
//   APB port: reg 0 (addr 0x0) refresh interval, reg 1 (addr 0x4) recovery
//     interval, both in microseconds; write only while the block is idle.
// Decision and throughput
//   The whole call decision is one compare/add pass from the req ports into
//   the state registers and the result register (or the skid entry while the
//   output register is full). One beat per cycle while rsp_ready stays high.
// Stall
//   Results sit in an output register backed by one skid entry, so one more
//   req beat is taken while a result waits; req_ready drops only when both
//   are full, and rises again once the receiver takes a beat.
// Reset
//   Synchronous, active high: state cleared, no flushing, no error,
//   intervals back to 100000 us and 1000000 us, result buffer empty.
`default_nettype none

`include "display_refresh_sequencer_defines.svh"

module display_refresh_sequencer #(
   parameter int BUFFER_BYTES = drs_pkg::BUFFER_BYTES_DEF,
   parameter int CHUNK_BYTES  = drs_pkg::CHUNK_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // Service call beats
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [31:0]                     req_now_us,
   input  wire logic                            req_init_ok,
   input  wire logic                            req_window_ok,
   input  wire logic                            req_chunk_ok,

   // Result beats
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_sent_init,
   output      logic                            rsp_new_frame,
   output      logic                            rsp_chunk_valid,
   output      logic [drs_pkg::OFFSET_W-1:0]    rsp_chunk_offset,
   output      logic [drs_pkg::LENGTH_W-1:0]    rsp_chunk_length,
   output      logic                            rsp_error_flag,
   output      logic                            rsp_frame_done,

   // Register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [drs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [drs_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [drs_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                            pready
);

   // Position must reach BUFFER_BYTES itself; math width covers both sizes.
   localparam int POS_W = $clog2(BUFFER_BYTES + 1);
   localparam int LEN_W = $clog2(CHUNK_BYTES + 1);
   localparam int MW    = (POS_W > LEN_W) ? POS_W : LEN_W;

   localparam logic [MW-1:0] BUF_M   = MW'(BUFFER_BYTES);
   localparam logic [MW-1:0] CHUNK_M = MW'(CHUNK_BYTES);

   // ---------------------------------------------------------------- CSRs
   logic [31:0] refresh_ivl_ff,  refresh_ivl_in;
   logic [31:0] recovery_ivl_ff, recovery_ivl_in;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      refresh_ivl_in  = refresh_ivl_ff;
      recovery_ivl_in = recovery_ivl_ff;
      if (csr_wr) begin
         case (paddr[2])
            drs_pkg::REG_REFRESH_IVL:  refresh_ivl_in  = pwdata;
            drs_pkg::REG_RECOVERY_IVL: recovery_ivl_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         drs_pkg::REG_REFRESH_IVL:  prdata = refresh_ivl_ff;
         drs_pkg::REG_RECOVERY_IVL: prdata = recovery_ivl_ff;
         default:                   prdata = '0;
      endcase
   end

   // --------------------------------------------------------- call state
   logic [31:0]      refresh_time_ff,  refresh_time_in;
   logic [31:0]      recovery_time_ff, recovery_time_in;
   logic [POS_W-1:0] pos_ff,           pos_in;
   logic             flushing_ff,      flushing_in;
   logic             recovering_ff,    recovering_in;
   logic             error_ff,         error_in;

   logic             in_fire;
   logic             out_fire;
   drs_pkg::rsp_type res;

   // Combinational call decision (mirrors one service call)
   logic [31:0]          rec_elapsed;
   logic [31:0]          ref_base;
   logic [31:0]          ref_elapsed;
   logic                 go;
   logic [MW-1:0]        pos_m;
   logic [MW-1:0]        remaining;
   logic [MW-1:0]        length;
   logic [MW-1:0]        pos_sum;
   logic [POS_W+drs_pkg::OFFSET_W-1:0] off_wide;
   logic [MW+drs_pkg::LENGTH_W-1:0]    len_wide;

   assign rec_elapsed = req_now_us - recovery_time_ff;

   always_comb begin
      refresh_time_in  = refresh_time_ff;
      recovery_time_in = recovery_time_ff;
      pos_in           = pos_ff;
      flushing_in      = flushing_ff;
      recovering_in    = recovering_ff;
      error_in         = error_ff;
      res              = '0;
      go               = 1'b1;
      ref_base         = refresh_time_ff;
      ref_elapsed      = '0;
      pos_m            = '0;
      remaining        = '0;
      length           = '0;
      pos_sum          = '0;
      off_wide         = '0;
      len_wide         = '0;

      // recovery: retry init at most once per recovery interval
      if (error_ff && !recovering_ff) begin
         if (rec_elapsed < recovery_ivl_ff) begin
            go = 1'b0;
         end else begin
            recovery_time_in = req_now_us;
            flushing_in      = 1'b0;
            res.sent_init    = 1'b1;
            if (!req_init_ok) begin
               go = 1'b0;
            end else begin
               recovering_in   = 1'b1;
               refresh_time_in = '0;
               ref_base        = '0;
            end
         end
      end

      // frame start
      ref_elapsed = req_now_us - ref_base;
      if (go && !flushing_in) begin
         if (ref_elapsed < refresh_ivl_ff) begin
            go = 1'b0;
         end else begin
            refresh_time_in = req_now_us;
            pos_in          = '0;
            flushing_in     = 1'b1;
            res.new_frame   = 1'b1;
            if (!req_window_ok) begin
               error_in      = 1'b1;
               flushing_in   = 1'b0;
               recovering_in = 1'b0;
               go            = 1'b0;
            end
         end
      end

      // chunk write
      pos_m     = MW'(pos_in);
      remaining = (pos_m < BUF_M) ? (BUF_M - pos_m) : '0;
      length    = (remaining > CHUNK_M) ? CHUNK_M : remaining;
      pos_sum   = pos_m + length;
      if (go) begin
         res.chunk_valid  = 1'b1;
         off_wide         = {{drs_pkg::OFFSET_W{1'b0}}, pos_in};
         len_wide         = {{drs_pkg::LENGTH_W{1'b0}}, length};
         res.chunk_offset = off_wide[drs_pkg::OFFSET_W-1:0];
         res.chunk_length = len_wide[drs_pkg::LENGTH_W-1:0];
         if (!req_chunk_ok) begin
            error_in      = 1'b1;
            flushing_in   = 1'b0;
            recovering_in = 1'b0;
         end else begin
            pos_in = pos_sum[POS_W-1:0];
            if (pos_sum >= BUF_M) begin
               flushing_in    = 1'b0;
               recovering_in  = 1'b0;
               error_in       = 1'b0;
               res.frame_done = 1'b1;
            end
         end
      end
      res.error_flag = error_in;
   end

   // --------------------------------------------------- result buffering
   drs_pkg::rsp_type main_ff, main_in;
   drs_pkg::rsp_type skid_ff, skid_in;
   logic             main_vld_ff, main_vld_in;
   logic             skid_vld_ff, skid_vld_in;

   assign req_ready = !skid_vld_ff;
   assign rsp_valid = main_vld_ff;
   assign in_fire   = req_valid & req_ready;
   assign out_fire  = rsp_valid & rsp_ready;

   always_comb begin
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (out_fire) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            main_vld_in = 1'b0;
         end
      end
      if (in_fire) begin
         if (!main_vld_in) begin
            main_in     = res;
            main_vld_in = 1'b1;
         end else begin
            skid_in     = res;
            skid_vld_in = 1'b1;
         end
      end
   end

   assign rsp_sent_init    = main_ff.sent_init;
   assign rsp_new_frame    = main_ff.new_frame;
   assign rsp_chunk_valid  = main_ff.chunk_valid;
   assign rsp_chunk_offset = main_ff.chunk_offset;
   assign rsp_chunk_length = main_ff.chunk_length;
   assign rsp_error_flag   = main_ff.error_flag;
   assign rsp_frame_done   = main_ff.frame_done;

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_ivl_ff   <= drs_pkg::REFRESH_IVL_RESET;
         recovery_ivl_ff  <= drs_pkg::RECOVERY_IVL_RESET;
         refresh_time_ff  <= '0;
         recovery_time_ff <= '0;
         pos_ff           <= '0;
         flushing_ff      <= 1'b0;
         recovering_ff    <= 1'b0;
         error_ff         <= 1'b0;
         main_vld_ff      <= 1'b0;
         skid_vld_ff      <= 1'b0;
      end else begin
         refresh_ivl_ff  <= refresh_ivl_in;
         recovery_ivl_ff <= recovery_ivl_in;
         if (in_fire) begin
            refresh_time_ff  <= refresh_time_in;
            recovery_time_ff <= recovery_time_in;
            pos_ff           <= pos_in;
            flushing_ff      <= flushing_in;
            recovering_ff    <= recovering_in;
            error_ff         <= error_in;
         end
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // ----------------------------------------------------------- assertions
   `DRS_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_vld_ff, main_vld_ff,
      "skid entry held while output register empty")
   `DRS_ASSERT_NOW(a_stall_only_on_backpressure, clock, reset, !req_ready,
      rsp_valid && main_vld_ff && skid_vld_ff, "req stalled without pending results")
   `DRS_ASSERT_NOW(a_done_is_clean_chunk, clock, reset, rsp_valid && rsp_frame_done,
      rsp_chunk_valid && !rsp_error_flag, "frame end without a clean chunk write")
   `DRS_ASSERT_NEXT(a_err_tracks_state, clock, reset, in_fire,
      main_vld_ff && (skid_vld_ff ? skid_ff.error_flag == error_ff
                                  : main_ff.error_flag == error_ff),
      "reported error flag differs from stored error state")

endmodule

`default_nettype wire

>>> verif/tb_display_refresh_sequencer.sv
// Self-checking testbench for display_refresh_sequencer: random service calls vs. a local model.
`timescale 1ns / 100ps

module tb_display_refresh_sequencer;

   // One service call as it is offered on the req channel.
   typedef struct {
      logic [31:0] now_us;
      logic        init_ok;
      logic        window_ok;
      logic        chunk_ok;
   } service_call_type;

   // ---------------------------------------------------------------------
   // Clock, reset and every DUT input, all known from time zero
   // ---------------------------------------------------------------------
   logic                           clock;
   logic                           reset         = 1'b1;

   logic                           req_valid     = 1'b0;
   logic [31:0]                    req_now_us    = '0;
   logic                           req_init_ok   = 1'b0;
   logic                           req_window_ok = 1'b0;
   logic                           req_chunk_ok  = 1'b0;
   logic                           rsp_ready     = 1'b0;

   logic                           psel          = 1'b0;
   logic                           penable       = 1'b0;
   logic                           pwrite        = 1'b0;
   logic [drs_pkg::CSR_ADDR_W-1:0] paddr         = '0;
   logic [drs_pkg::CSR_DATA_W-1:0] pwdata        = '0;

   wire                            req_ready;
   wire                            rsp_valid;
   wire                            rsp_sent_init;
   wire                            rsp_new_frame;
   wire                            rsp_chunk_valid;
   wire [drs_pkg::OFFSET_W-1:0]    rsp_chunk_offset;
   wire [drs_pkg::LENGTH_W-1:0]    rsp_chunk_length;
   wire                            rsp_error_flag;
   wire                            rsp_frame_done;
   wire [drs_pkg::CSR_DATA_W-1:0]  prdata;
   wire                            pready;

   // 8 ns period
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   display_refresh_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_us       (req_now_us),
      .req_init_ok      (req_init_ok),
      .req_window_ok    (req_window_ok),
      .req_chunk_ok     (req_chunk_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sent_init    (rsp_sent_init),
      .rsp_new_frame    (rsp_new_frame),
      .rsp_chunk_valid  (rsp_chunk_valid),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_frame_done   (rsp_frame_done),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   service_call_type  pending_calls[$];     // calls waiting for the driver
   drs_pkg::rsp_type  expected_results[$];  // predicted result beats, oldest first

   int unsigned   send_idle_pct = 0;    // chance per cycle that the sender idles
   int unsigned   recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   logic          hold_kick = 1'b0;     // one-cycle pulse: start a long receiver hold-off
   int unsigned   hold_left = 0;

   bit [31:0]     sim_us;               // running microsecond clock for the generator

   int unsigned   mismatch_count = 0;
   int unsigned   calls_taken = 0;
   int unsigned   frames_done = 0;
   int unsigned   frames_started = 0;
   int unsigned   init_tries = 0;
   int unsigned   chunk_beats = 0;

   // ---------------------------------------------------------------------
   // Local model of the sequencer: config copy plus call-to-call state
   // ---------------------------------------------------------------------
   bit [31:0]     cfg_refresh_us  = drs_pkg::REFRESH_IVL_RESET;
   bit [31:0]     cfg_recovery_us = drs_pkg::RECOVERY_IVL_RESET;

   bit [31:0]     mdl_last_refresh  = '0;
   bit [31:0]     mdl_last_recovery = '0;
   int unsigned   mdl_flush_pos     = 0;
   bit            mdl_flushing      = 1'b0;
   bit            mdl_recovering    = 1'b0;
   bit            mdl_error         = 1'b0;

   // Advance the model by one service call and return the result it owes.
   function automatic drs_pkg::rsp_type predict_call(input service_call_type c);
      drs_pkg::rsp_type r;
      bit          go;
      bit [31:0]   elapsed;
      int unsigned remaining;
      int unsigned len;
      r  = '0;
      go = 1'b1;

      // In error with no recovery running: retry init once per recovery interval.
      if (mdl_error && !mdl_recovering) begin
         elapsed = c.now_us - mdl_last_recovery;   // modulo 2^32, survives wrap
         if (elapsed < cfg_recovery_us) begin
            go = 1'b0;
         end else begin
            mdl_last_recovery = c.now_us;
            mdl_flushing      = 1'b0;
            r.sent_init       = 1'b1;
            if (!c.init_ok) begin
               go = 1'b0;
            end else begin
               mdl_recovering   = 1'b1;
               mdl_last_refresh = '0;              // forces an immediate frame check
            end
         end
      end

      // Not mid-frame: start a new frame once the refresh interval has passed.
      if (go && !mdl_flushing) begin
         elapsed = c.now_us - mdl_last_refresh;
         if (elapsed < cfg_refresh_us) begin
            go = 1'b0;
         end else begin
            mdl_last_refresh = c.now_us;
            mdl_flush_pos    = 0;
            mdl_flushing     = 1'b1;
            r.new_frame      = 1'b1;
            if (!c.window_ok) begin
               mdl_error      = 1'b1;
               mdl_flushing   = 1'b0;
               mdl_recovering = 1'b0;
               go             = 1'b0;
            end
         end
      end

      // One chunk per call; a position at or past the end gives a zero-length chunk.
      if (go) begin
         remaining = (mdl_flush_pos < drs_pkg::BUFFER_BYTES_DEF) ?
                     drs_pkg::BUFFER_BYTES_DEF - mdl_flush_pos : 0;
         len = (remaining > drs_pkg::CHUNK_BYTES_DEF) ? drs_pkg::CHUNK_BYTES_DEF : remaining;
         r.chunk_valid  = 1'b1;
         r.chunk_offset = mdl_flush_pos[drs_pkg::OFFSET_W-1:0];
         r.chunk_length = len[drs_pkg::LENGTH_W-1:0];
         if (!c.chunk_ok) begin
            mdl_error      = 1'b1;
            mdl_flushing   = 1'b0;
            mdl_recovering = 1'b0;
         end else begin
            mdl_flush_pos += len;
            if (mdl_flush_pos >= drs_pkg::BUFFER_BYTES_DEF) begin
               mdl_flushing   = 1'b0;
               mdl_recovering = 1'b0;
               mdl_error      = 1'b0;   // a full frame clears the error
               r.frame_done   = 1'b1;
            end
         end
      end

      r.error_flag = mdl_error;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: pops calls from pending_calls, holds each beat until accepted.
   // Prediction happens at the accepting edge, from the payload on the pins.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      service_call_type taken;
      service_call_type next_call;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken.now_us    = req_now_us;
            taken.init_ok   = req_init_ok;
            taken.window_ok = req_window_ok;
            taken.chunk_ok  = req_chunk_ok;
            expected_results.push_back(predict_call(taken));
            calls_taken++;
         end
         // Slot is free when nothing is offered or the offered beat just went in.
         if (!req_valid || req_ready) begin
            if (pending_calls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_call     = pending_calls.pop_front();
               req_valid     <= 1'b1;
               req_now_us    <= next_call.now_us;
               req_init_ok   <= next_call.init_ok;
               req_window_ok <= next_call.window_ok;
               req_chunk_ok  <= next_call.chunk_ok;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the stimulus only has to kick it.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= 200;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver backpressure: random stalls, or solid low during a hold-off.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every accepted result beat against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      drs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat arrived with no prediction pending");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("sent_init",    want.sent_init,    rsp_sent_init);
            check_field("new_frame",    want.new_frame,    rsp_new_frame);
            check_field("chunk_valid",  want.chunk_valid,  rsp_chunk_valid);
            check_field("chunk_offset", want.chunk_offset, rsp_chunk_offset);
            check_field("chunk_length", want.chunk_length, rsp_chunk_length);
            check_field("error_flag",   want.error_flag,   rsp_error_flag);
            check_field("frame_done",   want.frame_done,   rsp_frame_done);
            init_tries     += want.sent_init;
            frames_started += want.new_frame;
            chunk_beats    += want.chunk_valid;
            frames_done    += want.frame_done;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // APB write: setup then access; the register takes the value at the access edge.
   task automatic csr_write(input logic reg_sel,
                            input logic [drs_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == drs_pkg::REG_REFRESH_IVL) begin
         cfg_refresh_us = value;
      end else begin
         cfg_recovery_us = value;
      end
   endtask

   task automatic push_call(input logic [31:0] now_us, input logic init_ok,
                            input logic window_ok, input logic chunk_ok);
      service_call_type c;
      c.now_us    = now_us;
      c.init_ok   = init_ok;
      c.window_ok = window_ok;
      c.chunk_ok  = chunk_ok;
      pending_calls.push_back(c);
   endtask

   // Mostly well-formed traffic: time marches forward in steps aimed at the
   // interval boundaries, bus steps mostly succeed so whole frames complete.
   // About one call in ten is noise: arbitrary time and outcome bits.
   task automatic queue_random_calls(input int count);
      bit [31:0] step;
      @(negedge clock);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0) begin
            push_call($urandom, $urandom_range(1) != 0, $urandom_range(1) != 0,
                      $urandom_range(1) != 0);
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3: step = $urandom_range(64);
               4:          step = cfg_refresh_us - 1;
               5:          step = cfg_refresh_us;
               6:          step = cfg_recovery_us - 1;
               7:          step = cfg_recovery_us;
               8:          step = $urandom_range(5000);
               default:    step = $urandom;
            endcase
            sim_us += step;
            push_call(sim_us, $urandom_range(3) != 0, $urandom_range(19) != 0,
                      $urandom_range(99) != 0);
         end
      end
   endtask

   // Block is quiet once nothing is queued, offered or owed.
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (pending_calls.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] refresh_us, input logic [31:0] recovery_us,
                            input int unsigned idle_pct, input int unsigned stall_pct,
                            input int count, input bit squeeze);
      csr_write(drs_pkg::REG_REFRESH_IVL, refresh_us);
      csr_write(drs_pkg::REG_RECOVERY_IVL, recovery_us);
      @(posedge clock);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      sim_us = $urandom;
      queue_random_calls(count);
      if (squeeze) begin
         // let traffic get going, then block the result side so the skid fills
         repeat (20) @(posedge clock);
         hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
      end
      wait_until_quiet();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed calls at reset intervals (refresh 100000, recovery 1000000).
      @(negedge clock);
      push_call(32'd0,       1'b1, 1'b1, 1'b1);  // too early for the first frame
      push_call(32'd99999,   1'b1, 1'b1, 1'b1);  // one microsecond short
      push_call(32'd100000,  1'b1, 1'b0, 1'b1);  // frame starts, window set fails
      push_call(32'd200000,  1'b1, 1'b1, 1'b1);  // in error, recovery interval not yet up
      push_call(32'd1000000, 1'b0, 1'b1, 1'b1);  // init tried and fails
      push_call(32'd1999999, 1'b1, 1'b1, 1'b1);  // one short of the next retry
      push_call(32'd2000000, 1'b1, 1'b1, 1'b0);  // init ok, frame, first chunk fails
      push_call(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1); // retry at the top of the time range
      for (int k = 0; k < 6; k++) begin
         push_call($urandom, 1'b0, 1'b0, 1'b1);  // mid-frame: init/window outcomes ignored
      end
      push_call(32'h0000_0000, 1'b1, 1'b1, 1'b0); // chunk failure mid-frame, time wrapped
      push_call(32'd999998,  1'b1, 1'b1, 1'b1);  // recovery wait measured across the wrap
      push_call(32'd999999,  1'b1, 1'b1, 1'b1);  // exactly one interval after the wrap
      push_call(32'd999999,  1'b1, 1'b1, 1'b1);
      push_call(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1);
      push_call(32'h5555_5555, 1'b1, 1'b1, 1'b1);
      wait_until_quiet();

      // Random phases: config settings, idling mode, and whether to squeeze.
      run_phase(32'd0,         32'd0,         0,  0,  235, 1'b0);  // back-to-back frames
      run_phase(32'd40,        32'd100,       47, 0,  235, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,  47, 235, 1'b0);  // intervals never end
      run_phase(32'd500,       32'd2000,      36, 36, 235, 1'b1);
      run_phase(drs_pkg::REFRESH_IVL_RESET, drs_pkg::RECOVERY_IVL_RESET, 0, 0, 235, 1'b1);
      run_phase(32'd1,         32'd1,         36, 36, 235, 1'b0);

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d predicted results never arrived", expected_results.size());
         mismatch_count++;
      end

      $display("covered %0d service calls: %0d frames started, %0d completed,",
               calls_taken, frames_started, frames_done);
      $display("  %0d chunk writes, %0d init retries, %0d mismatches",
               chunk_beats, init_tries, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
